### hdl/text_feature_hasher_top_assert.svh
// Assertion macros for the text feature hasher.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TEXT_FEATURE_HASHER_TOP_ASSERT_SVH
`define TEXT_FEATURE_HASHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TFH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TFH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFH_ASSERT(name, prop, msg)
`define TFH_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### hdl/tfh_pkg.sv
// Shared types and constants of the text feature hasher.
// Used by the front, queue, back and top level modules.
package tfh_pkg;

  localparam int FEAT_W = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int HASH_SEED = 17;
  localparam logic [7:0] GROUP_MARK = 8'h7C;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] DELIM_RESET = 8'h20;

  typedef enum logic {
    REC_FEATURE = 1'b0,
    REC_END     = 1'b1
  } rec_kind_e;

  typedef struct packed {
    logic              has_feat;
    logic [FEAT_W-1:0] feat_idx;
    logic              eol;
    logic              label;
  } tfh_event_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic label_of(input logic [7:0] b0, input logic [7:0] b1);
    logic r;
    r = 1'b0;
    if (is_space(b0) || b0 == CH_PLUS) begin
      r = (b1 == CH_ONE);
    end else if (is_digit(b0)) begin
      if (is_digit(b1)) begin
        r = (b0 == CH_ZERO) && (b1 == CH_ONE);
      end else begin
        r = (b0 == CH_ONE);
      end
    end
    return r;
  endfunction

endpackage

### hdl/tfh_front.sv
// Front part: accepts bytes, tracks tokens and hashes, and emits one event
// per byte that causes results. Depends on tfh_pkg.
module tfh_front import tfh_pkg::*; #(
  parameter int HASH_BITS = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_line_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       ev_valid_o,
  output tfh_event_t ev_o
);

  localparam int WW = HASH_BITS + 8;
  localparam logic [HASH_BITS-1:0] SEED_H = HASH_BITS'(HASH_SEED);

  logic [7:0]           delim_q;
  logic [HASH_BITS-1:0] ns_q, ns_d, tok_q, tok_d;
  logic                 inside_q, inside_d, group_q, group_d;
  logic                 pending_q, pending_d, stopped_q, stopped_d;
  logic [1:0]           pos_q, pos_d;
  logic [7:0]           lead_q, lead_d;
  logic                 label_q, label_d;

  logic [HASH_BITS-1:0] hash_base, hash_next;
  logic [WW-1:0]        base_w, sx_w, sum_w;
  logic                 feat;
  logic [FEAT_W-1:0]    feat_idx;
  logic                 ev_label;

  assign hash_base = inside_q ? tok_q : ((char_byte_i == GROUP_MARK) ? SEED_H : ns_q);
  assign base_w    = WW'(hash_base);
  assign sx_w      = {{(WW-8){char_byte_i[7]}}, char_byte_i};
  assign sum_w     = (base_w << 5) - base_w + sx_w;
  assign hash_next = sum_w[HASH_BITS-1:0];

  always_comb begin
    ns_d      = ns_q;
    tok_d     = tok_q;
    inside_d  = inside_q;
    group_d   = group_q;
    pending_d = pending_q;
    stopped_d = stopped_q;
    pos_d     = pos_q;
    lead_d    = lead_q;
    label_d   = label_q;
    feat      = 1'b0;
    feat_idx  = FEAT_W'(tok_q);
    ev_label  = 1'b0;

    if (pos_q == 2'd0) begin
      lead_d = char_byte_i;
      pos_d  = 2'd1;
    end else if (pos_q == 2'd1) begin
      label_d = label_of(lead_q, char_byte_i);
      pos_d   = 2'd2;
    end

    if (!stopped_q) begin
      if (char_byte_i == NUL_BYTE || char_byte_i == delim_q) begin
        if (inside_q) begin
          inside_d = 1'b0;
          if (group_q) begin
            ns_d    = tok_q;
            group_d = 1'b0;
          end else if (pending_q) begin
            pending_d = 1'b0;
          end else begin
            feat = 1'b1;
          end
        end
        stopped_d = (char_byte_i == NUL_BYTE);
      end else begin
        inside_d = 1'b1;
        if (!inside_q && char_byte_i == GROUP_MARK) begin
          group_d = 1'b1;
        end
        tok_d = hash_next;
      end
    end

    if (end_of_line_i) begin
      if (!stopped_d && inside_d && !group_d && !pending_d) begin
        feat     = 1'b1;
        feat_idx = FEAT_W'(tok_d);
      end
      ev_label  = (pos_d == 2'd1) ? label_of(lead_d, NUL_BYTE) : label_d;
      ns_d      = SEED_H;
      tok_d     = SEED_H;
      inside_d  = 1'b0;
      group_d   = 1'b0;
      pending_d = 1'b1;
      stopped_d = 1'b0;
      pos_d     = 2'd0;
      lead_d    = 8'd0;
      label_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q      <= SEED_H;
      tok_q     <= SEED_H;
      inside_q  <= 1'b0;
      group_q   <= 1'b0;
      pending_q <= 1'b1;
      stopped_q <= 1'b0;
      pos_q     <= 2'd0;
      lead_q    <= 8'd0;
      label_q   <= 1'b0;
    end else if (accept_i) begin
      ns_q      <= ns_d;
      tok_q     <= tok_d;
      inside_q  <= inside_d;
      group_q   <= group_d;
      pending_q <= pending_d;
      stopped_q <= stopped_d;
      pos_q     <= pos_d;
      lead_q    <= lead_d;
      label_q   <= label_d;
    end
  end

  assign ev_valid_o  = accept_i && (feat || end_of_line_i);
  assign ev_o.has_feat = feat;
  assign ev_o.feat_idx = feat_idx;
  assign ev_o.eol      = end_of_line_i;
  assign ev_o.label    = ev_label;

endmodule

### hdl/tfh_queue.sv
// Short event queue between the front and back parts.
// Depends on tfh_pkg for the event type and depth.
module tfh_queue import tfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  tfh_event_t wr_data_i,
  output logic       full_o,
  input  logic       rd_en_i,
  output tfh_event_t rd_data_o,
  output logic       empty_o
);

  tfh_event_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/tfh_back.sv
// Back part: expands each queued event into one or two result items.
// Depends on tfh_pkg for the event type and record kinds.
module tfh_back import tfh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  input  tfh_event_t        ev_i,
  output logic              ev_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic              record_kind_o,
  output logic [FEAT_W-1:0] feature_index_o,
  output logic              line_label_o,
  output logic              last_of_run_o
);

  logic phase_q, phase_d;
  logic two_rec, show_feat, take;

  assign two_rec   = ev_i.has_feat && ev_i.eol;
  assign show_feat = ev_i.has_feat && !phase_q;
  assign take      = pop_i && ev_valid_i;
  assign empty_o   = !ev_valid_i;
  assign ev_pop_o  = take && (!two_rec || phase_q);

  always_comb begin
    if (show_feat) begin
      record_kind_o   = REC_FEATURE;
      feature_index_o = ev_i.feat_idx;
      line_label_o    = 1'b0;
      last_of_run_o   = !ev_i.eol;
    end else begin
      record_kind_o   = REC_END;
      feature_index_o = '0;
      line_label_o    = ev_i.label;
      last_of_run_o   = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      phase_d = two_rec && !phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

### hdl/text_feature_hasher_top.sv
// Top level of the text feature hasher: front, event queue and back part.
// Depends on tfh_pkg, tfh_front, tfh_queue, tfh_back and the assertion header.
//
//   Channel   Handshake          Payload
//   input     push / full        char_byte_i, end_of_line_i
//   result    empty / pop        record_kind_o, feature_index_o, line_label_o, last_of_run_o
//   config    cfg_we_i           cfg_wdata_i (delimiter byte)
//
// One byte is taken per cycle unless full; its event is queued before the result ports.
// A byte with a feature and a line end gives two items, each taken by its own pop.
// Full rises only when all four entries of the event queue are occupied.
// Reset is asynchronous; the delimiter returns to a space and all line state clears.
`include "text_feature_hasher_top_assert.svh"
module text_feature_hasher_top import tfh_pkg::*; #(
  parameter int HASH_BITS = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        char_byte_i,
  input  logic              end_of_line_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output logic              empty,
  input  logic              pop,
  output logic              record_kind_o,
  output logic [FEAT_W-1:0] feature_index_o,
  output logic              line_label_o,
  output logic              last_of_run_o
);

  logic       accept;
  logic       ev_wr, ev_pop, q_empty;
  tfh_event_t ev_in, ev_head;

  assign accept = push && !full;

  tfh_front #(.HASH_BITS(HASH_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_byte_i  (char_byte_i),
    .end_of_line_i(end_of_line_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .ev_valid_o   (ev_wr),
    .ev_o         (ev_in)
  );

  tfh_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (ev_wr),
    .wr_data_i(ev_in),
    .full_o   (full),
    .rd_en_i  (ev_pop),
    .rd_data_o(ev_head),
    .empty_o  (q_empty)
  );

  tfh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ev_valid_i     (!q_empty),
    .ev_i           (ev_head),
    .ev_pop_o       (ev_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .record_kind_o  (record_kind_o),
    .feature_index_o(feature_index_o),
    .line_label_o   (line_label_o),
    .last_of_run_o  (last_of_run_o)
  );

  `TFH_ASSERT(a_end_rec_fields,
              !empty && record_kind_o |-> feature_index_o == '0 && last_of_run_o,
              "End item with index or not last")
  `TFH_ASSERT(a_feat_no_label, !empty && !record_kind_o |-> !line_label_o,
              "Feature item carries a label")
  `TFH_ASSERT_NEXT(a_eol_queued, accept && end_of_line_i, !empty,
                   "Line end byte produced no item")
  `TFH_ASSERT_NEXT(a_feat_then_end,
                   pop && !empty && !record_kind_o && !last_of_run_o,
                   !empty && record_kind_o,
                   "Feature before line end not followed by end item")

endmodule
